// ===== sv/six_digit_seven_segment_scanner_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SIX_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define SIX_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define SSDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ssds_pkg.sv =====
package ssds_pkg;

  localparam int unsigned ValueW = 20;
  localparam int unsigned SegW   = 7;
  localparam int unsigned NumPos = 6;
  localparam int unsigned PosW   = 3;
  localparam int unsigned DigitW = 4;

  localparam logic [ValueW-1:0] MaxShown = 20'd999999;
  localparam logic [DigitW-1:0] MaxDigit = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } ssds_state_e;

  // command from the sequencer to the digit unit
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] rem;
    logic [ValueW-1:0] weight;
  } ssds_cmd_t;

  // status from the digit unit
  typedef struct packed {
    logic              done;
    logic [DigitW-1:0] digit;
    logic [ValueW-1:0] rem;
  } ssds_stat_t;

  function automatic logic [ValueW-1:0] place_weight(input logic [PosW-1:0] pos);
    logic [ValueW-1:0] w;
    case (pos)
      3'd1:    w = 20'd10000;
      3'd2:    w = 20'd1000;
      3'd3:    w = 20'd100;
      3'd4:    w = 20'd10;
      3'd5:    w = 20'd1;
      default: w = 20'd100000;
    endcase
    return w;
  endfunction

  function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] s;
    case (digit)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/ssds_in_if.sv =====
interface ssds_in_if import ssds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] display_value;

  modport source (output valid, output display_value, input ready);
  modport sink   (input valid, input display_value, output ready);
endinterface

// ===== sv/ssds_out_if.sv =====
interface ssds_out_if import ssds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SegW-1:0]   segment_pattern;
  logic [NumPos-1:0] digit_enable_n;
  logic [PosW-1:0]   digit_position;
  logic              value_clamped;

  modport source (output valid, output segment_pattern, output digit_enable_n,
                  output digit_position, output value_clamped, input ready);
  modport sink   (input valid, input segment_pattern, input digit_enable_n,
                  input digit_position, input value_clamped, output ready);
endinterface

// ===== sv/ssds_digit_unit.sv =====
// Repeated-subtraction digit extractor: one compare and subtract per cycle.
module ssds_digit_unit import ssds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssds_cmd_t  cmd_i,
  output ssds_stat_t stat_o
);

  logic              running_q, running_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] weight_q, weight_d;
  logic [DigitW-1:0] digit_q, digit_d;
  logic              step;

  assign step = (rem_q >= weight_q) && (digit_q < MaxDigit);

  always_comb begin
    running_d = running_q;
    rem_d     = rem_q;
    weight_d  = weight_q;
    digit_d   = digit_q;
    if (cmd_i.start) begin
      running_d = 1'b1;
      rem_d     = cmd_i.rem;
      weight_d  = cmd_i.weight;
      digit_d   = '0;
    end else if (running_q) begin
      if (step) begin
        rem_d   = rem_q - weight_q;
        digit_d = digit_q + DigitW'(1);
      end else begin
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
    end else begin
      running_q <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    weight_q <= weight_d;
    digit_q  <= digit_d;
  end

  assign stat_o.done  = running_q && !step;
  assign stat_o.digit = digit_q;
  assign stat_o.rem   = rem_q;

endmodule

// ===== sv/six_digit_seven_segment_scanner.sv =====
// Six-digit multiplexed seven-segment scanner.
// in_chan_i (valid/ready): one transaction per refresh tick. display_value is
//   sampled only when the scan sits at digit position zero; above 999999 it
//   is clamped to 999999 and value_clamped is raised for the whole scan.
// out_chan_o (valid/ready): one transaction per tick with the segment
//   pattern (bit0 = a .. bit6 = g), the active-low one-of-six enable, the
//   position (0 = hundred-thousands) and the clamp flag.
// Sequence: the digit unit subtracts the place weight once per cycle, up to
//   nine times; a tick runs from accept through the digit unit's steps to
//   the emit step, which writes the result register. in_ready is low meanwhile.
// A new tick is taken only after the previous one has left the emit step.
// The result register parts the two sides: a new tick is accepted while the
//   previous result still waits; a stalled receiver only holds the block in
//   the emit step until the result register frees up.
// Reset: scan position, remainder and clamp flag clear, so ticks at
//   positions 1..5 before a first position-zero tick show zeros.
module six_digit_seven_segment_scanner import ssds_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  ssds_in_if.sink    in_chan_i,
  ssds_out_if.source out_chan_o
);

  ssds_state_e       state_q, state_d;
  logic [PosW-1:0]   scan_pos_q, scan_pos_d;   // position for the next tick
  logic [PosW-1:0]   cur_pos_q, cur_pos_d;     // position of the tick at work
  logic [ValueW-1:0] rem_q, rem_d;             // part of the value not yet shown
  logic              clamp_q, clamp_d;
  logic [DigitW-1:0] digit_q, digit_d;

  logic              out_valid_q, out_valid_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [NumPos-1:0] en_n_q, en_n_d;
  logic [PosW-1:0]   opos_q, opos_d;
  logic              oclamp_q, oclamp_d;

  logic [PosW-1:0]   pos_now;
  ssds_cmd_t         cmd;
  ssds_stat_t        stat;

  // unreachable codes 6 and 7 fold to position zero
  assign pos_now = (scan_pos_q >= PosW'(NumPos)) ? '0 : scan_pos_q;

  ssds_digit_unit u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  always_comb begin
    state_d     = state_q;
    scan_pos_d  = scan_pos_q;
    cur_pos_d   = cur_pos_q;
    rem_d       = rem_q;
    clamp_d     = clamp_q;
    digit_d     = digit_q;
    out_valid_d = out_valid_q && !out_chan_o.ready;
    seg_d       = seg_q;
    en_n_d      = en_n_q;
    opos_d      = opos_q;
    oclamp_d    = oclamp_q;
    cmd.start   = 1'b0;
    cmd.rem     = rem_q;
    cmd.weight  = place_weight(pos_now);
    in_chan_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_chan_i.ready = 1'b1;
        if (in_chan_i.valid) begin
          cmd.start = 1'b1;
          cur_pos_d = pos_now;
          if (pos_now == '0) begin
            // latch a new value at the start of a scan
            if (in_chan_i.display_value > MaxShown) begin
              cmd.rem = MaxShown;
              clamp_d = 1'b1;
            end else begin
              cmd.rem = in_chan_i.display_value;
              clamp_d = 1'b0;
            end
          end
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.done) begin
          rem_d   = stat.rem;
          digit_d = stat.digit;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_chan_o.ready) begin
          out_valid_d = 1'b1;
          seg_d       = seg_pattern(digit_q);
          en_n_d      = {NumPos{1'b1}} & ~(NumPos'(1) << cur_pos_q);
          opos_d      = cur_pos_q;
          oclamp_d    = clamp_q;
          scan_pos_d  = (cur_pos_q == PosW'(NumPos - 1)) ? '0 : cur_pos_q + PosW'(1);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_pos_q  <= '0;
      rem_q       <= '0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_pos_q  <= scan_pos_d;
      rem_q       <= rem_d;
      clamp_q     <= clamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q <= cur_pos_d;
    digit_q   <= digit_d;
    seg_q     <= seg_d;
    en_n_q    <= en_n_d;
    opos_q    <= opos_d;
    oclamp_q  <= oclamp_d;
  end

  assign out_chan_o.valid           = out_valid_q;
  assign out_chan_o.segment_pattern = seg_q;
  assign out_chan_o.digit_enable_n  = en_n_q;
  assign out_chan_o.digit_position  = opos_q;
  assign out_chan_o.value_clamped   = oclamp_q;

endmodule

// ===== sv/ssds_checker.sv =====
`include "six_digit_seven_segment_scanner_assert.svh"

module ssds_checker import ssds_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [SegW-1:0]   seg_i,
  input logic [NumPos-1:0] en_n_i,
  input logic [PosW-1:0]   pos_i
);

  // enable must match the reported position
  `SSDS_ASSERT(a_enable_pos, clk_i, rst_ni, out_valid_i |-> (pos_i < PosW'(NumPos)) && (en_n_i == ({NumPos{1'b1}} & ~(NumPos'(1) << pos_i))), "digit enable does not match position")

  // only decimal digit patterns are shown
  `SSDS_ASSERT(a_seg_legal, clk_i, rst_ni, out_valid_i |-> (seg_i == 7'h3F || seg_i == 7'h06 || seg_i == 7'h5B || seg_i == 7'h4F || seg_i == 7'h66 || seg_i == 7'h6D || seg_i == 7'h7D || seg_i == 7'h07 || seg_i == 7'h7F || seg_i == 7'h6F), "segment pattern is not a digit")

  // a tick keeps the block busy: no accept right after one
  `SSDS_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "input accepted twice in a row")

  // stalled result holds
  `SSDS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(seg_i) && $stable(pos_i), "stalled result changed")

endmodule

bind six_digit_seven_segment_scanner ssds_checker u_ssds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan_i.valid),
  .in_ready_i  (in_chan_i.ready),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .seg_i       (out_chan_o.segment_pattern),
  .en_n_i      (out_chan_o.digit_enable_n),
  .pos_i       (out_chan_o.digit_position)
);
